FILE: hdl/scc_pkg.sv
`default_nettype none

package scc_pkg;

  localparam int unsigned ListDepth = 4096;
  localparam int unsigned MaxHits   = 64;

  localparam int unsigned AddrW  = $clog2(ListDepth);
  localparam int unsigned CntW   = AddrW + 1;
  localparam int unsigned HitW   = $clog2(MaxHits + 1);
  localparam int unsigned TimeW  = 32;
  localparam int unsigned WinW   = 20;
  localparam int unsigned LagW   = 21;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = WinW;

  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpProbe   = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgWinHalfWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSelfMode     = 1'd1;

  localparam logic [WinW-1:0] WinResetVal = 20'd3000;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TimeW-1:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [LagW-1:0] lag;
    logic                   hit;
    logic                   last;
    logic                   truncated;
  } out_item_t;

  typedef struct packed {
    logic [WinW-1:0] window_half_width;
    logic            self_mode;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [TimeW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: hdl/spike_cross_correlogram_lags_core.sv
// load, restart, unused code: done in StIdle, next transaction accepted the following cycle
// probe: StAdv skips entries below the window, StScan walks it, StFlush ends; an empty list
//   goes to StFlush; one entry per cycle through the single read port of the time store
// a hit is held until the next hit or the end of the probe, then leaves via the output
//   register; result stalls pause the scan and hold the input off
// reset clears list count, window start, probe index and registers (window 3000, self off)
`default_nettype none

module spike_cross_correlogram_lags_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [scc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [scc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire scc_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output scc_pkg::out_item_t                 out_data_o
);

  scc_pkg::cfg_t             cfg_q;
  scc_pkg::mem_req_t         mem_req;
  logic [scc_pkg::TimeW-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_half_width <= scc_pkg::WinResetVal;
      cfg_q.self_mode         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        scc_pkg::CfgWinHalfWidth: cfg_q.window_half_width <= cfg_wdata_i;
        scc_pkg::CfgSelfMode:     cfg_q.self_mode         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  scc_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  scc_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire

FILE: hdl/scc_store.sv
`default_nettype none

module scc_store (
  input  wire logic                     clk_i,
  input  wire scc_pkg::mem_req_t        req_i,
  output logic [scc_pkg::TimeW-1:0]     rd_data_o
);

  logic [scc_pkg::TimeW-1:0] mem [scc_pkg::ListDepth];
  logic [scc_pkg::TimeW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while the walker pauses
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/scc_walk.sv
`default_nettype none

module scc_walk (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scc_pkg::cfg_t            cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire scc_pkg::in_item_t        in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output scc_pkg::out_item_t            out_data_o,
  output scc_pkg::mem_req_t             mem_req_o,
  input  wire logic [scc_pkg::TimeW-1:0] rd_data_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StAdv   = 4'b0010,
    StScan  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [scc_pkg::CntW-1:0]  count_q, count_d;
  logic [scc_pkg::AddrW-1:0] ws_q, ws_d;
  logic [scc_pkg::AddrW-1:0] ptr_q, ptr_d;
  logic [scc_pkg::TimeW-1:0] pidx_q, pidx_d;
  logic [scc_pkg::TimeW-1:0] t_q, t_d;
  logic [scc_pkg::HitW-1:0]  hits_q, hits_d;
  logic                      dropped_q, dropped_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [scc_pkg::LagW-1:0]  pend_lag_q, pend_lag_d;

  logic                      out_valid_q;
  scc_pkg::out_item_t        out_q;
  logic                      push;
  scc_pkg::out_item_t        push_item;
  logic                      can_push;

  logic [scc_pkg::TimeW:0]   s_ext, t_ext, w_ext;
  logic                      below, above, self_skip, has_next;
  logic [scc_pkg::AddrW-1:0] ptr_inc;
  logic [scc_pkg::AddrW-1:0] ptr_start;
  logic [scc_pkg::LagW-1:0]  lag_now;

  assign s_ext = {1'b0, rd_data_i};
  assign t_ext = {1'b0, t_q};
  assign w_ext = {{(scc_pkg::TimeW + 1 - scc_pkg::WinW){1'b0}}, cfg_i.window_half_width};

  assign below     = (s_ext + w_ext) < t_ext;
  assign above     = s_ext > (t_ext + w_ext);
  assign self_skip = cfg_i.self_mode
                   && ({{(scc_pkg::TimeW - scc_pkg::AddrW){1'b0}}, ptr_q} == pidx_q)
                   && (rd_data_i == t_q);
  assign has_next  = ({1'b0, ptr_q} + scc_pkg::CntW'(1)) < count_q;
  assign ptr_inc   = ptr_q + scc_pkg::AddrW'(1);
  assign ptr_start = ({1'b0, ws_q} >= count_q) ? '0 : ws_q;
  assign lag_now   = rd_data_i[scc_pkg::LagW-1:0] - t_q[scc_pkg::LagW-1:0];

  assign can_push  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ws_d         = ws_q;
    ptr_d        = ptr_q;
    pidx_d       = pidx_q;
    t_d          = t_q;
    hits_d       = hits_q;
    dropped_d    = dropped_q;
    pend_valid_d = pend_valid_q;
    pend_lag_d   = pend_lag_q;
    mem_req_o    = '0;
    push         = 1'b0;
    push_item    = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (in_data_i.opcode)
            scc_pkg::OpLoad: begin
              if (count_q < scc_pkg::CntW'(scc_pkg::ListDepth)) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = count_q[scc_pkg::AddrW-1:0];
                mem_req_o.wdata = in_data_i.sample_time;
                count_d         = count_q + scc_pkg::CntW'(1);
              end
            end
            scc_pkg::OpProbe: begin
              t_d          = in_data_i.sample_time;
              hits_d       = '0;
              dropped_d    = 1'b0;
              pend_valid_d = 1'b0;
              if (count_q == '0) begin
                state_d = StFlush;
              end else begin
                ptr_d           = ptr_start;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = ptr_start;
                state_d         = StAdv;
              end
            end
            scc_pkg::OpRestart: begin
              count_d = '0;
              ws_d    = '0;
              pidx_d  = '0;
            end
            default: ;
          endcase
        end
      end

      StAdv: begin
        // move the window start past entries that lie below the window
        if (has_next && below) begin
          ptr_d           = ptr_inc;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_inc;
        end else begin
          ws_d    = ptr_q;
          state_d = StScan;
        end
      end

      StScan: begin
        priority if (above) begin
          state_d = StFlush;
        end else if (below || self_skip) begin
          if (has_next) begin
            ptr_d           = ptr_inc;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_inc;
          end else begin
            state_d = StFlush;
          end
        end else if (hits_q >= scc_pkg::HitW'(scc_pkg::MaxHits)) begin
          dropped_d = 1'b1;
          state_d   = StFlush;
        end else if (!pend_valid_q || can_push) begin
          // previous hit goes out once we know it is not the last one
          if (pend_valid_q) begin
            push            = 1'b1;
            push_item.lag   = pend_lag_q;
            push_item.hit   = 1'b1;
          end
          pend_valid_d = 1'b1;
          pend_lag_d   = lag_now;
          hits_d       = hits_q + scc_pkg::HitW'(1);
          if (has_next) begin
            ptr_d           = ptr_inc;
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_inc;
          end else begin
            state_d = StFlush;
          end
        end else begin
          // output busy, hold position
        end
      end

      StFlush: begin
        if (can_push) begin
          push           = 1'b1;
          push_item.last = 1'b1;
          if (pend_valid_q) begin
            push_item.lag       = pend_lag_q;
            push_item.hit       = 1'b1;
            push_item.truncated = dropped_q;
          end
          pend_valid_d = 1'b0;
          pidx_d       = pidx_q + scc_pkg::TimeW'(1);
          state_d      = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      ws_q         <= '0;
      pidx_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ws_q         <= ws_d;
      pidx_q       <= pidx_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    t_q        <= t_d;
    hits_q     <= hits_d;
    dropped_q  <= dropped_d;
    pend_lag_q <= pend_lag_d;
    if (push) begin
      out_q <= push_item;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
